/* sv/fsmix_pkg.sv */
package fsmix_pkg;

    // pipeline depth, input register through output register
    localparam int NUM_STAGES = 6;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    typedef logic signed [15:0] angle_t;
    typedef logic [7:0]         position_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LEFT_MIN  = 3'd0,
        REG_LEFT_MAX  = 3'd1,
        REG_RIGHT_MIN = 3'd2,
        REG_RIGHT_MAX = 3'd3,
        REG_FLEX_MIN  = 3'd4,
        REG_FLEX_MAX  = 3'd5,
        REG_YAW_BIAS  = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic [7:0] left_min;
        logic [7:0] left_max;
        logic [7:0] right_min;
        logic [7:0] right_max;
        logic [7:0] flex_min;
        logic [7:0] flex_max;
        logic [7:0] yaw_bias;
    } cfg_regs_t;

    localparam cfg_regs_t CFG_RESET = '{
        left_min:  8'd0,
        left_max:  8'd180,
        right_min: 8'd0,
        right_max: 8'd180,
        flex_min:  8'd0,
        flex_max:  8'd180,
        yaw_bias:  8'd60
    };

    // input angle limits in degrees
    localparam angle_t PITCH_HI = 16'sd45;
    localparam angle_t YAW_LO   = -16'sd20;
    localparam angle_t YAW_HI   = 16'sd20;
    localparam angle_t FLEX_HI  = 16'sd120;

    // yaw offset that moves -20..20 onto 0..40
    localparam logic signed [5:0] YAW_SHIFT = 6'sd20;

    // q1.16 constants, and an integer gain factor
    localparam logic [16:0] Q_ONE  = 17'd65536;
    localparam logic [16:0] Q_HALF = 17'd32768;
    localparam logic [4:0]  GAIN_FACTOR = 5'd30;

    // reciprocal multipliers for division by small constants
    localparam logic [14:0] DIV45_MUL   = 15'd23302;
    localparam int          DIV45_SHIFT = 20;
    localparam logic [20:0] DIV15_MUL   = 21'd1118482;
    localparam int          DIV15_SHIFT = 24;
    localparam logic [19:0] DIV5_MUL    = 20'd838861;
    localparam int          DIV5_SHIFT  = 22;

endpackage

/* sv/fsmix_if.sv */
// target set channel
interface fsmix_in_if
    import fsmix_pkg::*;
();
    logic   valid;
    logic   ready;
    angle_t pitch_target;
    angle_t yaw_target;
    angle_t flexion_target;

    modport source (output valid, output pitch_target, output yaw_target,
                    output flexion_target, input ready);
    modport sink   (input valid, input pitch_target, input yaw_target,
                    input flexion_target, output ready);
endinterface

// servo position channel
interface fsmix_out_if
    import fsmix_pkg::*;
();
    logic      valid;
    logic      ready;
    position_t left_position;
    position_t right_position;
    position_t flexion_position;

    modport source (output valid, output left_position, output right_position,
                    output flexion_position, input ready);
    modport sink   (input valid, input left_position, input right_position,
                    input flexion_position, output ready);
endinterface

/* sv/finger_servo_mixer_top.sv */
// throughput: one transaction per cycle unless the output stalls; six register
// stages with a valid bit each, every stage drains on its own so bubbles close up
// behind a stalled output
// reset: rst_n clears all stage valid bits and loads the default servo limits
// and yaw bias into the configuration registers
module finger_servo_mixer_top
    import fsmix_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    fsmix_in_if.sink               targets,
    fsmix_out_if.source            positions
);

    // signed division by 45, truncated toward zero
    function automatic logic signed [9:0] div45(input logic signed [14:0] x);
        logic [13:0] mag;
        logic [28:0] prod;
        logic [8:0]  q;
        mag  = x[14] ? 14'(-x) : x[13:0];
        prod = mag * DIV45_MUL;
        q    = prod[DIV45_SHIFT +: 9];
        return x[14] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    endfunction

    // signed division by 120, truncated toward zero
    function automatic logic signed [9:0] div120(input logic signed [15:0] x);
        logic [14:0] mag;
        logic [32:0] prod;
        logic [8:0]  q;
        mag  = x[15] ? 15'(-x) : x[14:0];
        prod = mag[14:3] * DIV15_MUL;
        q    = {1'b0, prod[DIV15_SHIFT +: 8]};
        return x[15] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    endfunction

    // truncate q32 sum toward zero, add flexion gain, clamp to servo limits
    function automatic logic [7:0] finish(input logic signed [43:0] sum,
                                          input logic [3:0] gain,
                                          input logic [7:0] lo,
                                          input logic [7:0] hi);
        logic signed [11:0] whole;
        logic signed [12:0] t;
        logic signed [12:0] g;
        logic [7:0]         r;
        whole = $signed(sum[43:32]);
        t     = whole;
        if (sum[43] && (|sum[31:0]))
        begin
            t = t + 13'sd1;
        end
        g = t + $signed({9'b0, gain});
        if (g < $signed({5'b0, lo}))
        begin
            r = lo;
        end
        else if (g > $signed({5'b0, hi}))
        begin
            r = hi;
        end
        else
        begin
            r = g[7:0];
        end
        return r;
    endfunction

    cfg_regs_t cfg_reg;

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] stg_ready;

    // stage 1: clamped angles
    logic [5:0]        s1_pitch_reg, s1_pitch_next;
    logic signed [5:0] s1_yaw_reg, s1_yaw_next;
    logic [6:0]        s1_flex_reg, s1_flex_next;

    // stage 2: normalised yaw and flexion, mapping products
    logic signed [16:0] s2_ny_reg, s2_ny_next;
    logic [16:0]        s2_nf_reg, s2_nf_next;
    logic signed [14:0] s2_lprod_reg, s2_lprod_next;
    logic signed [14:0] s2_rprod_reg, s2_rprod_next;
    logic signed [15:0] s2_fprod_reg, s2_fprod_next;

    // stage 3: yaw product, gain, mapping quotients
    logic signed [33:0] s3_qmul_reg, s3_qmul_next;
    logic [3:0]         s3_gain_reg, s3_gain_next;
    logic signed [9:0]  s3_lq_reg, s3_lq_next;
    logic signed [9:0]  s3_rq_reg, s3_rq_next;
    logic signed [9:0]  s3_fq_reg, s3_fq_next;

    // stage 4: yaw offset, mapped pitch, flexion position
    logic signed [41:0] s4_offset_reg, s4_offset_next;
    logic signed [10:0] s4_lmap_reg, s4_lmap_next;
    logic signed [10:0] s4_rmap_reg, s4_rmap_next;
    logic [7:0]         s4_fpos_reg, s4_fpos_next;
    logic [3:0]         s4_gain_reg;

    // stage 5: q32 sums
    logic signed [43:0] s5_lsum_reg, s5_lsum_next;
    logic signed [43:0] s5_rsum_reg, s5_rsum_next;
    logic [7:0]         s5_fpos_reg;
    logic [3:0]         s5_gain_reg;

    // stage 6: output register
    logic [7:0] s6_left_reg, s6_left_next;
    logic [7:0] s6_right_reg, s6_right_next;
    logic [7:0] s6_flex_reg;

    // intermediates
    logic [5:0]         yaw_ofs;
    logic [38:0]        ny_prod;
    logic [16:0]        ny_q;
    logic [40:0]        nf_prod;
    logic signed [8:0]  ldiff, rdiff, fdiff;
    logic [16:0]        one_m_nf;
    logic [16:0]        nf_excess;
    logic [21:0]        gain_prod;
    logic signed [10:0] fmap;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_LEFT_MIN:  cfg_reg.left_min  <= cfg_data;
                REG_LEFT_MAX:  cfg_reg.left_max  <= cfg_data;
                REG_RIGHT_MIN: cfg_reg.right_min <= cfg_data;
                REG_RIGHT_MAX: cfg_reg.right_max <= cfg_data;
                REG_FLEX_MIN:  cfg_reg.flex_min  <= cfg_data;
                REG_FLEX_MAX:  cfg_reg.flex_max  <= cfg_data;
                REG_YAW_BIAS:  cfg_reg.yaw_bias  <= cfg_data;
                default:       cfg_reg           <= cfg_reg;
            endcase
        end
    end

    // per-stage ready: a stage takes data when empty or when it drains
    always_comb
    begin
        stg_ready[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || positions.ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            stg_ready[k] = !vld_reg[k] || stg_ready[k+1];
        end
    end

    assign targets.ready = stg_ready[0];

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (stg_ready[0])
            begin
                vld_reg[0] <= targets.valid;
            end
            for (int k = 1; k < NUM_STAGES; k++)
            begin
                if (stg_ready[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // stage 1 logic: clamp input angles
    always_comb
    begin
        if (targets.pitch_target < 16'sd0)
        begin
            s1_pitch_next = 6'd0;
        end
        else if (targets.pitch_target > PITCH_HI)
        begin
            s1_pitch_next = PITCH_HI[5:0];
        end
        else
        begin
            s1_pitch_next = targets.pitch_target[5:0];
        end

        if (targets.yaw_target < YAW_LO)
        begin
            s1_yaw_next = YAW_LO[5:0];
        end
        else if (targets.yaw_target > YAW_HI)
        begin
            s1_yaw_next = YAW_HI[5:0];
        end
        else
        begin
            s1_yaw_next = targets.yaw_target[5:0];
        end

        if (targets.flexion_target < 16'sd0)
        begin
            s1_flex_next = 7'd0;
        end
        else if (targets.flexion_target > FLEX_HI)
        begin
            s1_flex_next = FLEX_HI[6:0];
        end
        else
        begin
            s1_flex_next = targets.flexion_target[6:0];
        end
    end

    // stage 2 logic: normalise yaw and flexion, pitch and flexion products
    always_comb
    begin
        yaw_ofs    = 6'(s1_yaw_reg + YAW_SHIFT);
        ny_prod    = {yaw_ofs, 13'b0} * DIV5_MUL;
        ny_q       = ny_prod[DIV5_SHIFT +: 17];
        s2_ny_next = $signed(ny_q - Q_HALF);

        nf_prod    = {s1_flex_reg, 13'b0} * DIV15_MUL;
        s2_nf_next = nf_prod[DIV15_SHIFT +: 17];

        ldiff = $signed({1'b0, cfg_reg.left_max}) - $signed({1'b0, cfg_reg.left_min});
        rdiff = $signed({1'b0, cfg_reg.right_max}) - $signed({1'b0, cfg_reg.right_min});
        fdiff = $signed({1'b0, cfg_reg.flex_max}) - $signed({1'b0, cfg_reg.flex_min});

        s2_lprod_next = $signed({1'b0, s1_pitch_reg}) * ldiff;
        s2_rprod_next = $signed({1'b0, s1_pitch_reg}) * rdiff;
        s2_fprod_next = $signed({1'b0, s1_flex_reg}) * fdiff;
    end

    // stage 3 logic: yaw times remaining flexion, gain, divide mappings
    always_comb
    begin
        one_m_nf     = Q_ONE - s2_nf_reg;
        s3_qmul_next = s2_ny_reg * $signed({1'b0, one_m_nf});

        nf_excess = s2_nf_reg - Q_HALF;
        gain_prod = nf_excess * GAIN_FACTOR;
        s3_gain_next = (s2_nf_reg > Q_HALF) ? gain_prod[16 +: 4] : 4'd0;

        s3_lq_next = div45(s2_lprod_reg);
        s3_rq_next = div45(s2_rprod_reg);
        s3_fq_next = div120(s2_fprod_reg);
    end

    // stage 4 logic: scale by bias, add mapping minimums
    always_comb
    begin
        s4_offset_next = s3_qmul_reg * $signed({1'b0, cfg_reg.yaw_bias});
        s4_lmap_next   = $signed({3'b0, cfg_reg.left_min}) + s3_lq_reg;
        s4_rmap_next   = $signed({3'b0, cfg_reg.right_min}) + s3_rq_reg;
        fmap           = $signed({3'b0, cfg_reg.flex_min}) + s3_fq_reg;
        s4_fpos_next   = fmap[7:0];
    end

    // stage 5 logic: q32 sums with yaw offset
    always_comb
    begin
        s5_lsum_next = $signed({s4_lmap_reg, 32'b0}) + s4_offset_reg;
        s5_rsum_next = $signed({s4_rmap_reg, 32'b0}) - s4_offset_reg;
    end

    // stage 6 logic: truncate, gain, clamp
    always_comb
    begin
        s6_left_next  = finish(s5_lsum_reg, s5_gain_reg,
                               cfg_reg.left_min, cfg_reg.left_max);
        s6_right_next = finish(s5_rsum_reg, s5_gain_reg,
                               cfg_reg.right_min, cfg_reg.right_max);
    end

    // pipeline payload registers
    always_ff @(posedge clk)
    begin
        if (stg_ready[0])
        begin
            s1_pitch_reg <= s1_pitch_next;
            s1_yaw_reg   <= s1_yaw_next;
            s1_flex_reg  <= s1_flex_next;
        end
        if (stg_ready[1])
        begin
            s2_ny_reg    <= s2_ny_next;
            s2_nf_reg    <= s2_nf_next;
            s2_lprod_reg <= s2_lprod_next;
            s2_rprod_reg <= s2_rprod_next;
            s2_fprod_reg <= s2_fprod_next;
        end
        if (stg_ready[2])
        begin
            s3_qmul_reg <= s3_qmul_next;
            s3_gain_reg <= s3_gain_next;
            s3_lq_reg   <= s3_lq_next;
            s3_rq_reg   <= s3_rq_next;
            s3_fq_reg   <= s3_fq_next;
        end
        if (stg_ready[3])
        begin
            s4_offset_reg <= s4_offset_next;
            s4_lmap_reg   <= s4_lmap_next;
            s4_rmap_reg   <= s4_rmap_next;
            s4_fpos_reg   <= s4_fpos_next;
            s4_gain_reg   <= s3_gain_reg;
        end
        if (stg_ready[4])
        begin
            s5_lsum_reg <= s5_lsum_next;
            s5_rsum_reg <= s5_rsum_next;
            s5_fpos_reg <= s4_fpos_reg;
            s5_gain_reg <= s4_gain_reg;
        end
        if (stg_ready[5])
        begin
            s6_left_reg  <= s6_left_next;
            s6_right_reg <= s6_right_next;
            s6_flex_reg  <= s5_fpos_reg;
        end
    end

    // output channel
    assign positions.valid            = vld_reg[NUM_STAGES-1];
    assign positions.left_position    = s6_left_reg;
    assign positions.right_position   = s6_right_reg;
    assign positions.flexion_position = s6_flex_reg;

endmodule

/* sv/fsmix_checker.sv */
module fsmix_assert (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] left_position,
    input logic [7:0] right_position,
    input logic [7:0] flexion_position
);

    logic in_acc;
    logic drain;

    assign in_acc = in_valid && in_ready && rst_n;
    assign drain  = out_ready && rst_n;

    // stalled result keeps its valid
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped while stalled");

    // stalled result keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            $stable(left_position) && $stable(right_position) && $stable(flexion_position))
    else $error("output payload changed while stalled");

    // an empty output stage means the whole pipeline can take a transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
    else $error("input not ready with empty output stage");

    // an accepted transaction reaches the output if the output keeps draining meanwhile
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(in_acc, 6) && $past(drain, 1) && $past(drain, 2) && $past(drain, 3)
            && $past(drain, 4) && $past(drain, 5) |-> out_valid)
    else $error("result missing after pipeline latency");

endmodule

bind finger_servo_mixer_top fsmix_assert u_fsmix_assert (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (targets.valid),
    .in_ready         (targets.ready),
    .out_valid        (positions.valid),
    .out_ready        (positions.ready),
    .left_position    (positions.left_position),
    .right_position   (positions.right_position),
    .flexion_position (positions.flexion_position)
);
